// ----- rtl/apbu_pkg.sv -----
// Package for the ARGB pixel blend unit: blend mode codes and channel constants.
// No dependencies; used by apbu_chan and argb_pixel_blend_unit.
`timescale 1ns / 1ps
`default_nettype none
package apbu_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int PROD_W   = 2 * CHAN_W;
  localparam int ALPHA_CH = NUM_CHAN - 1;

  localparam logic [CHAN_W:0]   ALPHA_ONE = 9'd256;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hff;

  typedef enum logic [2:0] {
    MODE_NORMAL      = 3'd0,
    MODE_OVER        = 3'd1,
    MODE_MULTIPLY    = 3'd2,
    MODE_ADDITIVE    = 3'd3,
    MODE_SUBTRACTIVE = 3'd4,
    MODE_SCREEN      = 3'd5,
    MODE_LIGHTEN     = 3'd6,
    MODE_DARKEN      = 3'd7
  } blend_mode_t;

  localparam blend_mode_t MODE_RESET = MODE_NORMAL;

endpackage
`default_nettype wire

// ----- rtl/apbu_chan.sv -----
// One 8-bit channel of the blend datapath: multiply stage, then mode select stage.
// Depends on apbu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apbu_chan (
  input  wire logic                       clk,
  input  wire logic                       en_mul,
  input  wire logic                       en_sel,
  input  wire logic                       is_alpha,
  input  wire apbu_pkg::blend_mode_t      mode,
  input  wire logic [apbu_pkg::CHAN_W-1:0] s,
  input  wire logic [apbu_pkg::CHAN_W-1:0] d,
  input  wire logic [apbu_pkg::CHAN_W-1:0] sa,
  output logic      [apbu_pkg::CHAN_W-1:0] c
);

  localparam int W  = apbu_pkg::CHAN_W;
  localparam int PW = apbu_pkg::PROD_W;

  logic [W:0]      inv;
  logic [W-1:0]    mul_sel;
  logic [PW:0]     prod_d;
  logic [PW-1:0]   p1_nxt;
  logic [PW-1:0]   p2_nxt;

  logic [PW-1:0]          p1_r;
  logic [PW-1:0]          p2_r;
  logic [W-1:0]           s_r;
  logic [W-1:0]           d_r;
  apbu_pkg::blend_mode_t  mode_r;
  logic                   alpha_r;

  logic [PW-1:0]   sum_n;
  logic [W-1:0]    hi1;
  logic [W-1:0]    hi2;
  logic [W:0]      add9;
  logic [W:0]      scr9;
  logic [W-1:0]    c_nxt;
  logic [W-1:0]    c_r;

  always_comb begin
    inv     = apbu_pkg::ALPHA_ONE - {1'b0, sa};
    mul_sel = (mode == apbu_pkg::MODE_NORMAL && !is_alpha) ? sa : d;
    p1_nxt  = PW'({{W{1'b0}}, s} * {{W{1'b0}}, mul_sel});
    prod_d  = {{(W+1){1'b0}}, d} * {{W{1'b0}}, inv};
    p2_nxt  = prod_d[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      s_r     <= s;
      d_r     <= d;
      mode_r  <= mode;
      alpha_r <= is_alpha;
    end
  end

  always_comb begin
    sum_n = p1_r + p2_r;
    hi1   = p1_r[PW-1:W];
    hi2   = p2_r[PW-1:W];
    add9  = {1'b0, s_r} + {1'b0, d_r};
    scr9  = add9 - {1'b0, hi1};
    unique case (mode_r)
      apbu_pkg::MODE_NORMAL:      c_nxt = alpha_r ? W'(s_r + hi2) : sum_n[PW-1:W];
      apbu_pkg::MODE_OVER:        c_nxt = W'(s_r + hi2);
      apbu_pkg::MODE_MULTIPLY:    c_nxt = hi1;
      apbu_pkg::MODE_ADDITIVE:    c_nxt = add9[W] ? apbu_pkg::CHAN_MAX : add9[W-1:0];
      apbu_pkg::MODE_SUBTRACTIVE: c_nxt = (d_r > s_r) ? W'(d_r - s_r) : '0;
      apbu_pkg::MODE_SCREEN:      c_nxt = scr9[W] ? apbu_pkg::CHAN_MAX : scr9[W-1:0];
      apbu_pkg::MODE_LIGHTEN:     c_nxt = (s_r > d_r) ? s_r : d_r;
      apbu_pkg::MODE_DARKEN:      c_nxt = (s_r < d_r) ? s_r : d_r;
      default:                    c_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_sel) begin
      c_r <= c_nxt;
    end
  end

  assign c = c_r;

endmodule
`default_nettype wire

// ----- rtl/argb_pixel_blend_unit.sv -----
// Top level of the ARGB8888 pixel blend unit: input stage, four channel lanes, mode register.
// Depends on apbu_pkg and apbu_chan.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one source/destination pixel pair per clock and returns one blended
// pixel per item through an input register, a multiply stage
// (source times alpha or destination, destination times inverse alpha, per channel) and
// a mode select stage that drives the output register. busy stays low, so start may be
// held high every cycle; out_valid marks each result for one cycle and it must be taken
// then, since the receiver cannot stall. The blend mode is sampled with each item on
// acceptance; write cfg_blend_mode only while no item is in flight.
module argb_pixel_blend_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [apbu_pkg::PIX_W-1:0]   in_src_pixel,
  input  wire logic [apbu_pkg::PIX_W-1:0]   in_dst_pixel,
  output logic                              out_valid,
  output logic      [apbu_pkg::PIX_W-1:0]   out_pixel,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_blend_mode
);

  localparam int W = apbu_pkg::CHAN_W;

  apbu_pkg::blend_mode_t        blend_mode_r;
  logic                         in_acc;

  logic [apbu_pkg::PIX_W-1:0]   src_r;
  logic [apbu_pkg::PIX_W-1:0]   dst_r;
  apbu_pkg::blend_mode_t        item_mode_r;
  logic                         v0_r;
  logic                         v1_r;
  logic                         out_valid_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= apbu_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blend_mode_r <= apbu_pkg::blend_mode_t'(cfg_blend_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= in_acc;
      v1_r        <= v0_r;
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r       <= in_src_pixel;
      dst_r       <= in_dst_pixel;
      item_mode_r <= blend_mode_r;
    end
  end

  for (genvar i = 0; i < apbu_pkg::NUM_CHAN; i++) begin : g_chan
    apbu_chan u_chan (
      .clk      (clk),
      .en_mul   (v0_r),
      .en_sel   (v1_r),
      .is_alpha (i == apbu_pkg::ALPHA_CH),
      .mode     (item_mode_r),
      .s        (src_r[i*W +: W]),
      .d        (dst_r[i*W +: W]),
      .sa       (src_r[apbu_pkg::ALPHA_CH*W +: W]),
      .c        (out_pixel[i*W +: W])
    );
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##3 out_valid)
    else $error("accepted item did not come out three cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 3))
    else $error("result strobe without a matching accepted item");

  a_stage_chain: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> out_valid)
    else $error("item dropped between select stage and output");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !v1_r && !v0_r)
    else $error("pipeline valid bits not cleared by reset");
`endif

endmodule
`default_nettype wire

// ----- sim/argb_pixel_blend_unit_test.sv -----
// Self-checking testbench for argb_pixel_blend_unit: directed and random pixel pairs in
// all eight blend modes, checked against an in-bench per-channel blend predictor.
// Depends on apbu_pkg and the argb_pixel_blend_unit RTL.
`timescale 1ns / 1ps
module argb_pixel_blend_unit_test;

  localparam int PIX_W    = apbu_pkg::PIX_W;
  localparam int CHAN_W   = apbu_pkg::CHAN_W;
  localparam int NUM_CHAN = apbu_pkg::NUM_CHAN;
  localparam int ALPHA_CH = apbu_pkg::ALPHA_CH;

  typedef struct {
    apbu_pkg::blend_mode_t mode;
    logic [PIX_W-1:0]      src;
    logic [PIX_W-1:0]      dst;
    logic [PIX_W-1:0]      pixel;
  } blend_expect_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      in_src_pixel = '0;
  logic [PIX_W-1:0]      in_dst_pixel = '0;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  apbu_pkg::blend_mode_t cfg_blend_mode = apbu_pkg::MODE_NORMAL;

  blend_expect_t         pending_pixels[$];
  apbu_pkg::blend_mode_t active_mode = apbu_pkg::MODE_RESET;
  int                    gap_max = 8;
  int                    mismatches = 0;
  int                    pixels_checked = 0;
  int                    pixels_per_mode[8];

  argb_pixel_blend_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_src_pixel   (in_src_pixel),
    .in_dst_pixel   (in_dst_pixel),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_blend_mode (cfg_blend_mode)
  );

  always #2 clk = ~clk;

  function automatic logic [PIX_W-1:0] blend_pixel(apbu_pkg::blend_mode_t mode,
                                                   logic [PIX_W-1:0] src,
                                                   logic [PIX_W-1:0] dst);
    int s;
    int d;
    int sa;
    int inv;
    int v;
    logic [PIX_W-1:0] res;
    sa  = src[PIX_W-1 -: CHAN_W];
    inv = 256 - sa;
    res = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      s = src[ch*CHAN_W +: CHAN_W];
      d = dst[ch*CHAN_W +: CHAN_W];
      case (mode)
        apbu_pkg::MODE_NORMAL: begin
          if (ch == ALPHA_CH) v = sa + ((d * inv) >> 8);
          else v = (s * sa + d * inv) >> 8;
        end
        apbu_pkg::MODE_OVER:        v = s + ((d * inv) >> 8);
        apbu_pkg::MODE_MULTIPLY:    v = (s * d) >> 8;
        apbu_pkg::MODE_ADDITIVE:    v = (s + d > 255) ? 255 : s + d;
        apbu_pkg::MODE_SUBTRACTIVE: v = (d > s) ? d - s : 0;
        apbu_pkg::MODE_SCREEN: begin
          v = s + d - ((s * d) >> 8);
          if (v > 255) v = 255;
        end
        apbu_pkg::MODE_LIGHTEN:     v = (s > d) ? s : d;
        default:                    v = (s < d) ? s : d;
      endcase
      res[ch*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    px = $urandom;
    case ($urandom_range(0, 5))
      0: px[PIX_W-1 -: CHAN_W] = 8'h00;
      1: px[PIX_W-1 -: CHAN_W] = 8'hff;
      2: begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          case ($urandom_range(0, 2))
            0: px[ch*CHAN_W +: CHAN_W] = 8'h00;
            1: px[ch*CHAN_W +: CHAN_W] = 8'hff;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  always @(posedge clk) begin
    blend_expect_t exp_item;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel: expected none, actual %h", $time, out_pixel);
        end else begin
          exp_item = pending_pixels.pop_front();
          pixels_checked++;
          pixels_per_mode[exp_item.mode]++;
          if (out_pixel !== exp_item.pixel) begin
            mismatches++;
            $display("%0t: %s src %h dst %h: expected %h, actual %h", $time,
                     exp_item.mode.name(), exp_item.src, exp_item.dst, exp_item.pixel,
                     out_pixel);
          end
        end
      end
      if (start && !busy) begin
        exp_item.mode  = active_mode;
        exp_item.src   = in_src_pixel;
        exp_item.dst   = in_dst_pixel;
        exp_item.pixel = blend_pixel(active_mode, in_src_pixel, in_dst_pixel);
        pending_pixels.push_back(exp_item);
      end
      if (cfg_valid && cfg_ready) active_mode = cfg_blend_mode;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_src_pixel <= src;
    in_dst_pixel <= dst;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic set_blend_mode(input apbu_pkg::blend_mode_t mode);
    wait_drained();
    cfg_valid      <= 1'b1;
    cfg_blend_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_mode();
    send_pixel(32'hff102030, 32'h80405060);
    send_pixel(32'h00ffffff, 32'hff000000);
  endtask

  task automatic test_mode_extremes();
    for (int m = 0; m < 8; m++) begin
      set_blend_mode(apbu_pkg::blend_mode_t'(m));
      send_pixel(32'hffffffff, 32'hffffffff);
      send_pixel(32'h00000000, 32'hffffffff);
    end
  endtask

  task automatic test_over_wrap();
    set_blend_mode(apbu_pkg::MODE_OVER);
    send_pixel(32'h80ffffff, 32'hffffffff);
    send_pixel(32'h01c0c0c0, 32'hff808080);
  endtask

  task automatic test_random_blend();
    apbu_pkg::blend_mode_t mode;
    for (int phase = 0; phase < 10; phase++) begin
      mode = (phase < 8) ? apbu_pkg::blend_mode_t'(7 - phase)
                         : apbu_pkg::blend_mode_t'($urandom_range(0, 7));
      set_blend_mode(mode);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      repeat (80) send_pixel(rand_pixel(), rand_pixel());
    end
    gap_max = 8;
  endtask

  initial begin
    int modes_seen;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_mode();
    test_mode_extremes();
    test_over_wrap();
    test_random_blend();
    wait_drained();
    repeat (8) @(posedge clk);
    modes_seen = 0;
    foreach (pixels_per_mode[m]) if (pixels_per_mode[m] > 0) modes_seen++;
    $display("Blended %0d pixel pairs over %0d of 8 modes, with and without input gaps.",
             pixels_checked, modes_seen);
    $display("Mismatching pixels: %0d", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d pixels still pending", pending_pixels.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
